[rtl/rhf_pkg.sv]
// Shared types and constants for the recent history filter.
`timescale 1ns / 1ps

package rhf_pkg;

	// Widths of the request and response fields.
	localparam int CLASS_W = 2;
	localparam int INDEX_W = 16;
	localparam int KEY_W   = INDEX_W + 1;

	// Request opcodes.
	typedef enum logic {
		OP_QUERY = 1'b0,
		OP_PUSH  = 1'b1
	} op_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

[rtl/rhf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module rhf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/rhf_slots.sv]
// Per-class write slot pointers and ring-full flags.
`timescale 1ns / 1ps

module rhf_slots #(
	parameter int NUM_CLASSES = 4,
	parameter int RING_DEPTH  = 32,
	localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
	localparam int SW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CIDX_W-1:0] cls,
	input  logic              bump,
	output logic [SW-1:0]     slot,
	output logic              full
);

	localparam logic [SW-1:0] LAST = SW'(RING_DEPTH - 1);

	logic [SW-1:0] slot_q [NUM_CLASSES];
	logic          full_q [NUM_CLASSES];

	// The selected class's pointer; the ring fills from slot zero upward.
	assign slot = slot_q[cls];
	assign full = full_q[cls];

	// Advance the pointer with wraparound; a wrap marks every slot written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				slot_q[c] <= '0;
				full_q[c] <= 1'b0;
			end
		end else if (bump) begin
			if (slot_q[cls] == LAST) begin
				slot_q[cls] <= '0;
				full_q[cls] <= 1'b1;
			end else begin
				slot_q[cls] <= slot_q[cls] + SW'(1);
			end
		end
	end

endmodule

[rtl/recent_history_filter_unit.sv]
// Top level of the recent history filter: sequencer, ring scan and response register.
//
//   Channel   Signals                                     Direction
//   request   in_valid, in_ready, opcode, class_select,   in
//             item_index
//   response  out_valid, out_ready, hit                   out
//
// A push goes from acceptance to ST_DONE, where its response is loaded. A query passes
// through ST_SCAN and ST_DRAIN before ST_DONE loads its response. The scan reads one
// ring entry per cycle from the single read port of the history RAM. ST_DONE waits until
// the response register is free, and in_ready returns in ST_IDLE after the load.
// One request is in flight at a time.
// Reset clears all pointers and full flags; the RAM is not cleared, since a
// slot counts as filled only below the class pointer or once the ring has wrapped.
// A stalled response holds in its register while the next request is accepted.
`timescale 1ns / 1ps

module recent_history_filter_unit #(
	parameter int NUM_CLASSES = 4,
	parameter int RING_DEPTH  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic [rhf_pkg::CLASS_W-1:0]  class_select,
	input  logic [rhf_pkg::INDEX_W-1:0]  item_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit
);

	import rhf_pkg::*;

	localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int DEPTH  = NUM_CLASSES * RING_DEPTH;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] RD_A = AW'(RING_DEPTH);
	localparam logic [SW-1:0] LAST = SW'(RING_DEPTH - 1);
	localparam int NCW = $clog2(NUM_CLASSES + 1) + CLASS_W;

	state_t state_q, state_d;

	logic              accept;
	logic              cls_ok;
	logic [CIDX_W-1:0] cls_idx;
	logic [SW-1:0]     cur_slot;
	logic              cur_full;
	logic [AW-1:0]     base_a;

	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [AW-1:0]     base_q;
	logic [SW-1:0]     lim_slot_q;
	logic              lim_full_q;
	logic [SW-1:0]     scan_idx_q;
	logic              hit_acc_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [INDEX_W-1:0] ram_rdata;

	logic              rd_vld_s1;
	logic              ent_vld_s1;

	logic              out_valid_q;
	logic              hit_q;
	logic              load_out;

	// Request decode.
	assign accept  = in_valid && in_ready;
	assign cls_ok  = (NCW'(class_select) < NCW'(NUM_CLASSES));
	assign cls_idx = CIDX_W'(class_select);
	assign base_a  = AW'(cls_idx) * RD_A;

	// Per-class pointers; a push bumps the pointer of its class.
	rhf_slots #(
		.NUM_CLASSES (NUM_CLASSES),
		.RING_DEPTH  (RING_DEPTH)
	) u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.cls    (cls_idx),
		.bump   (ram_we),
		.slot   (cur_slot),
		.full   (cur_full)
	);

	// A push writes index plus one into the current slot at acceptance.
	assign ram_we    = accept && (opcode == OP_PUSH) && cls_ok;
	assign ram_waddr = base_a + AW'(cur_slot);
	assign ram_re    = (state_q == ST_SCAN);
	assign ram_raddr = base_q + AW'(scan_idx_q);

	rhf_ram #(
		.WIDTH (INDEX_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item_index + INDEX_W'(1)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer next state and handshake.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == OP_QUERY && cls_ok) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (scan_idx_q == LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request capture; the class limits are frozen for the whole scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= opcode;
			key_q      <= {1'b0, item_index} + KEY_W'(1);
			base_q     <= base_a;
			lim_slot_q <= cur_slot;
			lim_full_q <= cur_full;
		end
	end

	// Scan index walks the ring one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
		end else if (accept) begin
			scan_idx_q <= '0;
		end else if (state_q == ST_SCAN && scan_idx_q != LAST) begin
			scan_idx_q <= scan_idx_q + SW'(1);
		end
	end

	// Read tag pipeline, aligned with the RAM's registered data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		ent_vld_s1 <= lim_full_q || (scan_idx_q < lim_slot_q);
	end

	// Hit accumulation over written entries of the ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_acc_q <= 1'b0;
		end else if (accept) begin
			hit_acc_q <= 1'b0;
		end else if (rd_vld_s1 && ent_vld_s1 && ({1'b0, ram_rdata} == key_q)) begin
			hit_acc_q <= 1'b1;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_q <= hit_acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

	// A push never reports a hit.
	a_push_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && op_q == OP_PUSH) |-> !hit_acc_q)
		else $error("push request carries a hit");

	// The history RAM is written only while no request is in flight.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("history write outside idle");

	// A scan always starts at the first ring entry.
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && state_d == ST_SCAN) |=> (scan_idx_q == '0))
		else $error("scan did not start at entry zero");

	// Read data is only compared on the cycle after a read was issued.
	a_read_tag: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ($past(state_q) == ST_SCAN))
		else $error("read tag without a scan read");

endmodule
